>>> rtl/pwfm_pkg.sv
// Shared constants, codes and control types of the pulse width and frequency meter.
`default_nettype none
package pwfm_pkg;

  localparam int NUM_BITS = 30;
  localparam int DEN_BITS = 20;
  localparam int FILT_BITS = 24;
  localparam int WUS_BITS = 13;
  localparam int OUT_BITS = 20;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam int IN_DATA_BITS = 16;
  localparam int IN_USER_BITS = 2;
  localparam int OUT_DATA_BITS = 80;

  localparam logic [OUT_BITS-1:0] US_PER_SECOND = 20'd1000000;
  localparam logic [DEN_BITS-1:0] DEN_MAX = '1;
  localparam logic [WUS_BITS-1:0] WIDTH_MAX = 13'd8191;
  localparam logic [7:0] CLOCK_MHZ_RESET = 8'd84;
  localparam logic [3:0] FILTER_WEIGHT_RESET = 4'd4;

  localparam logic [1:0] OP_RISE = 2'd0;
  localparam logic [1:0] OP_FALL = 2'd1;
  localparam logic [1:0] OP_GATE = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_CLOCK_MHZ = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_WEIGHT = 2'd1;

  localparam logic [1:0] SEL_FILTER = 2'd0;
  localparam logic [1:0] SEL_WIDTH = 2'd1;
  localparam logic [1:0] SEL_RATIO = 2'd2;
  localparam logic [1:0] SEL_PERIOD = 2'd3;

  typedef struct packed {
    logic       count_edge;
    logic       capture;
    logic       gate_end;
    logic       clear_all;
    logic       load;
    logic       start;
    logic       store;
    logic       clr_pending;
    logic       push;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic pending;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/pwfm_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module pwfm_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff = trial - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> rtl/pwfm_ctrl.sv
// Sequencer of the meter: decodes words and steps the divider passes of a compute.
`default_nettype none
module pwfm_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [1:0]  in_op_i,
  output logic             in_ready_o,
  input  wire pwfm_pkg::sts_t sts_i,
  output pwfm_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       take;

  assign in_ready_o = (state_q == S_IDLE);
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    cmd_o = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_PUSH;
          unique case (in_op_i)
            pwfm_pkg::OP_RISE: cmd_o.count_edge = 1'b1;
            pwfm_pkg::OP_FALL: cmd_o.capture = !sts_i.freq_zero;
            pwfm_pkg::OP_GATE: cmd_o.gate_end = 1'b1;
            pwfm_pkg::OP_COMPUTE: begin
              if (sts_i.freq_zero) begin
                cmd_o.clear_all = 1'b1;
              end else if (sts_i.pending) begin
                sel_d = pwfm_pkg::SEL_FILTER;
                state_d = S_LOAD;
              end
            end
            default: state_d = S_PUSH;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = S_START;
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.store = 1'b1;
          if (sel_q == pwfm_pkg::SEL_PERIOD) begin
            cmd_o.clr_pending = 1'b1;
            state_d = S_PUSH;
          end else begin
            sel_d = sel_q + 2'd1;
            state_d = S_LOAD;
          end
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q <= pwfm_pkg::SEL_FILTER;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pwfm_dp.sv
// Datapath of the meter: counters, filter state, operand staging, divider and result register.
`default_nettype none
module pwfm_dp #(
  parameter int COUNT_BITS = 20,
  parameter int TICK_BITS = 16,
  parameter int WIDTH_SCALE = 127
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [pwfm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [pwfm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire logic [pwfm_pkg::IN_DATA_BITS-1:0]    width_ticks_i,
  input  wire pwfm_pkg::cmd_t                       cmd_i,
  output pwfm_pkg::sts_t                            sts_o,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic [pwfm_pkg::OUT_DATA_BITS-1:0]        out_data_o
);

  localparam int SAMPLE_BITS = (TICK_BITS < pwfm_pkg::IN_DATA_BITS) ? TICK_BITS
                                                                    : pwfm_pkg::IN_DATA_BITS;
  localparam int NW = pwfm_pkg::NUM_BITS;
  localparam int DW = pwfm_pkg::DEN_BITS;
  localparam int FB = pwfm_pkg::FILT_BITS;
  localparam int WB = pwfm_pkg::WUS_BITS;
  localparam int OB = pwfm_pkg::OUT_BITS;
  localparam int PROD_BITS = COUNT_BITS + WB;
  localparam int FEXT_BITS = COUNT_BITS + DW;
  localparam logic [7:0] SCALE = 8'(WIDTH_SCALE);

  logic [7:0]             clk_mhz_q;
  logic [3:0]             fw_q;
  logic [COUNT_BITS-1:0]  edge_q;
  logic [COUNT_BITS-1:0]  freq_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   pending_q;
  logic [FB-1:0]          filt_q;
  logic [WB-1:0]          width_q;
  logic [OB-1:0]          period_q;
  logic [OB-1:0]          ratio_q;
  logic [NW-1:0]          num_q, num_d;
  logic [DW-1:0]          den_q, den_d;
  logic                   out_valid_q;
  logic [pwfm_pkg::OUT_DATA_BITS-1:0] out_data_q;

  logic [27:0]                filt_mul;
  logic [SAMPLE_BITS+7:0]     samp_mul;
  logic [27:0]                filt_x10;
  logic [7:0]                 clk_eff;
  logic [15:0]                scale_clk;
  logic [PROD_BITS-1:0]       fw_prod;
  logic [FEXT_BITS-1:0]       freq_ext;
  logic [COUNT_BITS+OB-1:0]   freq_out_ext;
  logic                       div_done;
  logic [NW-1:0]              quot;
  logic                       out_free;

  assign filt_mul = 28'(filt_q) * 28'(fw_q);
  assign samp_mul = (SAMPLE_BITS + 8)'(SCALE) * (SAMPLE_BITS + 8)'(sample_q);
  assign filt_x10 = (28'(filt_q) << 3) + (28'(filt_q) << 1);
  assign clk_eff = (clk_mhz_q == 8'd0) ? 8'd1 : clk_mhz_q;
  assign scale_clk = 16'(SCALE) * 16'(clk_eff);
  assign fw_prod = PROD_BITS'(freq_q) * PROD_BITS'(width_q);
  assign freq_ext = FEXT_BITS'(freq_q);
  assign freq_out_ext = (COUNT_BITS + OB)'(freq_q);

  always_comb begin
    num_d = NW'(pwfm_pkg::US_PER_SECOND);
    den_d = pwfm_pkg::DEN_MAX;
    unique case (cmd_i.sel)
      pwfm_pkg::SEL_FILTER: begin
        num_d = NW'(filt_mul) + NW'(samp_mul);
        den_d = DW'({1'b0, fw_q} + 5'd1);
      end
      pwfm_pkg::SEL_WIDTH: begin
        num_d = NW'(filt_x10);
        den_d = DW'(scale_clk);
      end
      pwfm_pkg::SEL_RATIO: begin
        if (fw_prod > PROD_BITS'(pwfm_pkg::DEN_MAX)) begin
          den_d = pwfm_pkg::DEN_MAX;
        end else begin
          den_d = DW'(fw_prod);
        end
      end
      pwfm_pkg::SEL_PERIOD: begin
        if (freq_ext > FEXT_BITS'(pwfm_pkg::DEN_MAX)) begin
          den_d = pwfm_pkg::DEN_MAX;
        end else begin
          den_d = DW'(freq_ext);
        end
      end
      default: den_d = pwfm_pkg::DEN_MAX;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  pwfm_div #(
    .NUM_W(NW),
    .DEN_W(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_mhz_q <= pwfm_pkg::CLOCK_MHZ_RESET;
      fw_q <= pwfm_pkg::FILTER_WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwfm_pkg::REG_CLOCK_MHZ: clk_mhz_q <= cfg_data_i;
        pwfm_pkg::REG_FILTER_WEIGHT: fw_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= '0;
      freq_q <= '0;
      sample_q <= '0;
      pending_q <= 1'b0;
      filt_q <= '0;
      width_q <= '0;
      period_q <= '0;
      ratio_q <= '0;
    end else begin
      if (cmd_i.count_edge && (edge_q != '1)) begin
        edge_q <= edge_q + COUNT_BITS'(1);
      end
      if (cmd_i.capture) begin
        sample_q <= width_ticks_i[SAMPLE_BITS-1:0];
        pending_q <= 1'b1;
      end
      if (cmd_i.gate_end) begin
        freq_q <= edge_q;
        edge_q <= '0;
      end
      if (cmd_i.clear_all) begin
        pending_q <= 1'b0;
        filt_q <= '0;
        width_q <= '0;
        period_q <= '0;
        ratio_q <= '0;
      end
      if (cmd_i.clr_pending) begin
        pending_q <= 1'b0;
      end
      if (cmd_i.store) begin
        unique case (cmd_i.sel)
          pwfm_pkg::SEL_FILTER: filt_q <= quot[FB-1:0];
          pwfm_pkg::SEL_WIDTH: begin
            if (quot > NW'(pwfm_pkg::WIDTH_MAX)) begin
              width_q <= pwfm_pkg::WIDTH_MAX;
            end else begin
              width_q <= quot[WB-1:0];
            end
          end
          pwfm_pkg::SEL_RATIO: ratio_q <= (width_q == '0) ? '0 : quot[OB-1:0];
          pwfm_pkg::SEL_PERIOD: period_q <= quot[OB-1:0];
          default: period_q <= period_q;
        endcase
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= {7'b0, ratio_q, period_q, width_q, freq_out_ext[OB-1:0]};
    end
  end

  assign sts_o.freq_zero = (freq_q == '0);
  assign sts_o.pending = pending_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule
`default_nettype wire

>>> rtl/pulse_width_frequency_meter.sv
// Top level of the pulse width and frequency meter.
// One channel of a pulse meter. Each input word carries an event in tuser (rising
// edge, falling edge with its captured tick count in tdata, gate end, compute) and
// yields exactly one output word holding the current frequency, filtered width in
// tenths of a microsecond, period in microseconds and period-over-width figure.
// Edge, capture and gate words go through the push state to the result register; a
// compute word with a fresh width sample makes four passes through one shared
// 30-bit restoring divider (filter, width scaling, ratio, period), each loading
// the operands, starting the divider, waiting for it and storing the quotient. The
// result register lets the next word enter while a result waits downstream.
// Configuration (clock_mhz at index 0, filter_weight at index 1) is to be written
// only while the block is idle, by the user: the block has no check for it.
`default_nettype none
module pulse_width_frequency_meter #(
  parameter int COUNT_BITS = 20,
  parameter int TICK_BITS = 16,
  parameter int WIDTH_SCALE = 127
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [pwfm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [pwfm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [15:0] width_ticks
  input  wire logic [pwfm_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  wire logic [pwfm_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [19:0] frequency, [32:20] width_us, [52:33] period_us,
  // [72:53] period_over_width, [79:73] zero
  output logic [pwfm_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata
);

  pwfm_pkg::cmd_t cmd;
  pwfm_pkg::sts_t sts;

  pwfm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pwfm_dp #(
    .COUNT_BITS (COUNT_BITS),
    .TICK_BITS  (TICK_BITS),
    .WIDTH_SCALE(WIDTH_SCALE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .width_ticks_i(s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> tb/sv/pwfm_checker.sv
// Checker for the pulse width and frequency meter: predicts each reading and compares it.
`default_nettype none
module pwfm_checker
  import pwfm_pkg::*;
#(
  parameter int WIDTH_SCALE = 127
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     s_axis_tvalid,
  input  wire logic                     s_axis_tready,
  // [15:0] width_ticks
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  wire logic [IN_USER_BITS-1:0]  s_axis_tuser,
  input  wire logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [19:0] frequency, [32:20] width_us, [52:33] period_us,
  // [72:53] period_over_width, [79:73] zero
  input  wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   results_o,
  output int unsigned                   filter_runs_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OUT_BITS-1:0] COUNT_MAX = '1;
  localparam longint unsigned US_SCALE = 10;
  localparam int unsigned PRINT_LIMIT = 60;

  typedef struct packed {
    logic [6:0]          pad;
    logic [OUT_BITS-1:0] period_over_width;
    logic [OUT_BITS-1:0] period_us;
    logic [WUS_BITS-1:0] width_us;
    logic [OUT_BITS-1:0] frequency;
  } reading_t;

  logic [7:0]           mhz_setting = CLOCK_MHZ_RESET;
  logic [3:0]           weight_setting = FILTER_WEIGHT_RESET;
  logic [OUT_BITS-1:0]  edge_tally = '0;
  logic [OUT_BITS-1:0]  freq_latched = '0;
  logic [15:0]          width_capture = '0;
  logic                 capture_fresh = 1'b0;
  logic [FILT_BITS-1:0] width_filter = '0;
  logic [WUS_BITS-1:0]  width_us_q = '0;
  logic [OUT_BITS-1:0]  period_us_q = '0;
  logic [OUT_BITS-1:0]  ratio_q = '0;

  reading_t    expected_readings[$];
  int unsigned mismatches = 0;
  int unsigned readings_seen = 0;
  int unsigned filter_runs = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    results_o = 0;
    filter_runs_o = 0;
  end

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: reading %0d, %s: expected %0d, got %0d", $time, readings_seen, field,
               want, got);
    mismatches++;
  endtask

  function automatic reading_t next_reading(input logic [1:0] op, input logic [15:0] ticks);
    reading_t        r;
    longint unsigned w;
    longint unsigned mhz;
    longint unsigned acc;
    case (op)
      OP_RISE: begin
        if (edge_tally != COUNT_MAX) edge_tally++;
      end
      OP_FALL: begin
        if (freq_latched != 0) begin
          width_capture = ticks;
          capture_fresh = 1'b1;
        end
      end
      OP_GATE: begin
        freq_latched = edge_tally;
        edge_tally = '0;
      end
      default: begin
        if (capture_fresh) begin
          if (freq_latched != 0) begin
            w = weight_setting;
            mhz = (mhz_setting == 0) ? 64'd1 : 64'(mhz_setting);
            acc = (64'(width_filter) * w + 64'(WIDTH_SCALE) * 64'(width_capture)) / (w + 64'd1);
            width_filter = acc[FILT_BITS-1:0];
            acc = 64'(width_filter) * US_SCALE / (64'(WIDTH_SCALE) * mhz);
            width_us_q = (acc > 64'(WIDTH_MAX)) ? WIDTH_MAX : acc[WUS_BITS-1:0];
            if (width_us_q == 0) ratio_q = '0;
            else begin
              acc = 64'(US_PER_SECOND) / (64'(freq_latched) * 64'(width_us_q));
              ratio_q = acc[OUT_BITS-1:0];
            end
            acc = 64'(US_PER_SECOND) / 64'(freq_latched);
            period_us_q = acc[OUT_BITS-1:0];
            filter_runs++;
          end
          capture_fresh = 1'b0;
        end
        if (freq_latched == 0) begin
          width_filter = '0;
          width_us_q = '0;
          period_us_q = '0;
          ratio_q = '0;
        end
      end
    endcase
    r.pad = '0;
    r.frequency = freq_latched;
    r.width_us = width_us_q;
    r.period_us = period_us_q;
    r.period_over_width = ratio_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      mhz_setting = CLOCK_MHZ_RESET;
      weight_setting = FILTER_WEIGHT_RESET;
      edge_tally = '0;
      freq_latched = '0;
      width_capture = '0;
      capture_fresh = 1'b0;
      width_filter = '0;
      width_us_q = '0;
      period_us_q = '0;
      ratio_q = '0;
      expected_readings.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CLOCK_MHZ:     mhz_setting = cfg_data_i;
          REG_FILTER_WEIGHT: weight_setting = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_readings.size() == 0) begin
          report_mismatch("word with nothing expected, frequency", 0, got.frequency);
        end else begin
          want = expected_readings.pop_front();
          if (got.frequency !== want.frequency)
            report_mismatch("frequency", want.frequency, got.frequency);
          if (got.width_us !== want.width_us)
            report_mismatch("width_us", want.width_us, got.width_us);
          if (got.period_us !== want.period_us)
            report_mismatch("period_us", want.period_us, got.period_us);
          if (got.period_over_width !== want.period_over_width)
            report_mismatch("period_over_width", want.period_over_width,
                            got.period_over_width);
          if (got.pad !== want.pad)
            report_mismatch("zero fill", want.pad, got.pad);
        end
        readings_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(next_reading(s_axis_tuser, s_axis_tdata));
    end
    fail_count_o <= mismatches;
    pending_o <= expected_readings.size();
    results_o <= readings_seen;
    filter_runs_o <= filter_runs;
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Top of the pulse width and frequency meter testbench: clock, reset, stimulus and verdict.
`default_nettype none
module tb_top;
  import pwfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_TAIL = 200;
  localparam int PHASE_WORDS = 105;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic [IN_USER_BITS-1:0]  s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned filter_runs;

  int          tx_idle_pct = 12;
  int          rx_idle_pct = 70;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned settings_applied = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  pulse_width_frequency_meter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pwfm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .filter_runs_o(filter_runs)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [15:0] ticks);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ticks;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [7:0] mhz, input logic [3:0] weight,
                               input bit with_spare);
    logic [3:0] junk;
    junk = 4'($urandom);
    drain();
    if (with_spare) begin
      write_reg(REG_SPARE_2, 8'hFF);
      write_reg(REG_SPARE_3, 8'h00);
    end
    write_reg(REG_CLOCK_MHZ, mhz);
    write_reg(REG_FILTER_WEIGHT, {junk, weight});
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic run_measurement();
    int edges;
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(9))
        0:       edges = 0;
        1:       edges = $urandom_range(20, 60);
        default: edges = $urandom_range(1, 6);
      endcase
      repeat (edges) send_word(OP_RISE, 16'($urandom));
      send_word(OP_GATE, 16'($urandom));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(3) == 0) send_word(OP_COMPUTE, 16'($urandom));
        send_word(OP_FALL, pick_ticks());
        send_word(OP_COMPUTE, 16'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 5)) send_word(2'($urandom), 16'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty meter: compute clears, capture ignored, gate with no edges
    send_word(OP_COMPUTE, 16'h0000);
    send_word(OP_FALL, 16'hFFFF);
    send_word(OP_GATE, 16'hFFFF);
    send_word(OP_COMPUTE, 16'hFFFF);
    // one edge per gate: longest period, then zero width
    send_word(OP_RISE, 16'h5555);
    send_word(OP_GATE, 16'hAAAA);
    send_word(OP_FALL, 16'h0000);
    send_word(OP_COMPUTE, 16'h0000);
    send_word(OP_FALL, 16'hFFFF);
    send_word(OP_COMPUTE, 16'h0000);
    send_word(OP_COMPUTE, 16'h0000);
    repeat (3) send_word(OP_RISE, 16'h0000);
    send_word(OP_GATE, 16'h0000);
    send_word(OP_FALL, 16'd1000);
    send_word(OP_COMPUTE, 16'h0000);

    apply_setting(8'd1, 4'd0, 1'b1);
    send_word(OP_FALL, 16'hFFFF);
    send_word(OP_COMPUTE, 16'h0000);
    apply_setting(8'd0, 4'd15, 1'b0);
    send_word(OP_FALL, 16'd40000);
    send_word(OP_COMPUTE, 16'h0000);
    send_word(OP_GATE, 16'h0000);
    send_word(OP_COMPUTE, 16'h0000);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       apply_setting(CLOCK_MHZ_RESET, FILTER_WEIGHT_RESET, 1'b0);
        1:       apply_setting(8'd255, 4'd15, 1'b0);
        2:       apply_setting(8'd1, 4'd0, 1'b0);
        3:       apply_setting(8'd0, 4'd9, 1'b1);
        4:       apply_setting(8'($urandom_range(1, 255)), 4'($urandom), 1'b0);
        default: apply_setting(8'd16, 4'd1, 1'b0);
      endcase
      case (ph / 2)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct <= 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct <= 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (ph == 5) hold_asked <= hold_asked + 1;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) run_measurement();
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    $display("covered %0d input words and %0d readings, %0d filter updates", words_sent,
             results, filter_runs);
    $display("over %0d register settings, three idle mixes and one long output hold-off",
             settings_applied);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
